/* rtl/pcni_pkg.sv */
// shared types and constants of the periodic cell neighbor id block
`timescale 1ns / 1ps

package pcni_pkg;

    localparam int CELL_ID_W      = 32;
    localparam int LEVEL_W        = 3;
    localparam int FACE_W         = 3;
    localparam int NID_W          = 32;
    localparam int REG_W          = 36;
    localparam int NUM_REGS       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int FACE_COUNT     = 6;

    localparam int MAX_LEVELS_DEF = 4;
    localparam int ID_WIDTH_DEF   = 32;
    localparam int DIM_WIDTH_DEF  = 12;

    typedef struct packed {
        logic [CELL_ID_W-1:0] cell_id;
        logic [LEVEL_W-1:0]   cell_level;
        logic [FACE_W-1:0]    face;
    } in_t;

    typedef struct packed {
        logic [NID_W-1:0] neighbor_id;
        logic             too_wide;
    } out_t;

endpackage

/* rtl/pcni_div.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pcni_div #(
    parameter int DW = 48,
    parameter int BW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [BW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [BW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] dvs_reg;
    logic [BW:0]   trial;
    logic [BW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = ge ? (trial - {1'b0, dvs_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= diff[BW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/pcni_seq.sv */
// sequencer with shared multiply-add unit: decode, face step, re-encode
`timescale 1ns / 1ps

module pcni_seq #(
    parameter int MAX_LEVELS = pcni_pkg::MAX_LEVELS_DEF,
    parameter int ID_WIDTH   = pcni_pkg::ID_WIDTH_DEF,
    parameter int DIM_WIDTH  = pcni_pkg::DIM_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  pcni_pkg::in_t                            item,
    input  logic [MAX_LEVELS-1:0][pcni_pkg::REG_W-1:0] dims,
    output logic                                     busy,
    output logic                                     done,
    output pcni_pkg::out_t                           result
);

    localparam int GW  = (MAX_LEVELS * DIM_WIDTH > 64) ? 64 : MAX_LEVELS * DIM_WIDTH;
    localparam int DW  = (3 * DIM_WIDTH > GW) ? 3 * DIM_WIDTH : GW;
    localparam int WW  = $clog2(3 * DIM_WIDTH + 1);
    localparam int TW  = $clog2(MAX_LEVELS * 3 * DIM_WIDTH + 1);
    localparam int LW  = $clog2(MAX_LEVELS + 1);
    localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int XW  = DW + ID_WIDTH;
    localparam int RW  = pcni_pkg::REG_W;
    localparam int RXW = (3 * DIM_WIDTH > RW) ? 3 * DIM_WIDTH : RW;
    localparam int NW  = pcni_pkg::NID_W;
    localparam int FW  = pcni_pkg::FACE_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CNT    = 11'b00000000010,
        S_FIELD  = 11'b00000000100,
        S_DIV    = 11'b00000001000,
        S_FOLD   = 11'b00000010000,
        S_FACE   = 11'b00000100000,
        S_ESTART = 11'b00001000000,
        S_EDIV   = 11'b00010000000,
        S_CH     = 11'b00100000000,
        S_PACK   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } seq_state_t;

    function automatic logic [WW-1:0] bits_for(input logic [DW-1:0] n);
        logic [WW-1:0] b;
        b = WW'(1);
        for (int i = 0; i < DW; i++)
        begin
            if (n[i])
                b = WW'(i + 1);
        end
        return b;
    endfunction

    seq_state_t state_reg, state_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [LW-1:0]        num_reg, num_next;
    logic [2:0]           step_reg, step_next;
    logic [FW-1:0]        face_reg, face_next;
    logic [ID_WIDTH-1:0]  id_reg, id_next;
    logic [ID_WIDTH-1:0]  acc_reg, acc_next;
    logic [TW-1:0]        total_reg, total_next;
    logic [DW-1:0]        cnt_reg, cnt_next;
    logic [GW-1:0]        g_reg [3];
    logic [GW-1:0]        g_next [3];
    logic [GW-1:0]        full_reg [3];
    logic [GW-1:0]        full_next [3];
    logic [DIM_WIDTH-1:0] part_reg [3];
    logic [DIM_WIDTH-1:0] part_next [3];
    logic [WW-1:0]        wid_reg [MAX_LEVELS];

    logic [LIW-1:0]       lidx;
    logic [RXW-1:0]       dim_ext;
    logic [DIM_WIDTH-1:0] n_cur [3];
    logic [WW-1:0]        wid_new;
    logic                 wid_we;
    logic [XW-1:0]        id_ext;
    logic [DW-1:0]        v_val;
    logic [DW-1:0]        k_val;
    logic [LW-1:0]        lvl_sat;
    logic [GW-1:0]        g_face [3];
    logic [GW-1:0]        g_inc [3];

    logic [DW-1:0]           mul_a;
    logic [DIM_WIDTH-1:0]    mul_b;
    logic [DW-1:0]           mul_c;
    logic [DW+DIM_WIDTH-1:0] mul_prod;
    logic [DW-1:0]           mul_p;

    logic                 div_start;
    logic [DW-1:0]        div_a;
    logic [DIM_WIDTH-1:0] div_b;
    logic                 div_done;
    logic [DW-1:0]        div_quot;
    logic [DIM_WIDTH-1:0] div_rem;

    pcni_div #(
        .DW(DW),
        .BW(DIM_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // counts of the current level, zero read as one
    always_comb
    begin
        lidx    = lvl_reg[LIW-1:0];
        dim_ext = RXW'(dims[lidx]);
        for (int d = 0; d < 3; d++)
        begin
            n_cur[d] = dim_ext[d*DIM_WIDTH +: DIM_WIDTH];
            if (n_cur[d] == '0)
                n_cur[d] = DIM_WIDTH'(1);
        end
    end

    // child index field of the current level, clamped to 1..count
    always_comb
    begin
        wid_new = bits_for(cnt_reg);
        id_ext  = XW'(id_reg);
        for (int i = 0; i < DW; i++)
            v_val[i] = id_ext[i] & (32'(wid_new) > i);
        if (v_val == '0)
            v_val = DW'(1);
        if (v_val > cnt_reg)
            v_val = cnt_reg;
        k_val = v_val - DW'(1);
    end

    always_comb
    begin
        if (item.cell_level == '0)
            lvl_sat = LW'(1);
        else if (32'(item.cell_level) > MAX_LEVELS)
            lvl_sat = LW'(MAX_LEVELS);
        else
            lvl_sat = LW'(item.cell_level);
    end

    // periodic step across the chosen face
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            g_inc[d]  = g_reg[d] + GW'(1);
            g_face[d] = g_reg[d];
            if ((32'(face_reg) < pcni_pkg::FACE_COUNT) && (32'(face_reg[FW-1:1]) == d))
            begin
                if (face_reg[0])
                    g_face[d] = (g_inc[d] == full_reg[d]) ? '0 : g_inc[d];
                else
                    g_face[d] = (g_reg[d] == '0) ? (full_reg[d] - GW'(1))
                                                 : (g_reg[d] - GW'(1));
            end
        end
    end

    // shared multiply-add operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        case (state_reg)
            S_CNT:
            begin
                if (step_reg == 3'd0)
                begin
                    mul_a = DW'(n_cur[0]);
                    mul_b = n_cur[1];
                end
                else
                begin
                    mul_a = cnt_reg;
                    mul_b = n_cur[2];
                end
            end
            S_FOLD:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = DW'(g_reg[0]);
                        mul_b = n_cur[0];
                        mul_c = DW'(part_reg[0]);
                    end
                    3'd1:
                    begin
                        mul_a = DW'(g_reg[1]);
                        mul_b = n_cur[1];
                        mul_c = DW'(part_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = DW'(g_reg[2]);
                        mul_b = n_cur[2];
                        mul_c = DW'(part_reg[2]);
                    end
                    3'd3:
                    begin
                        mul_a = DW'(full_reg[0]);
                        mul_b = n_cur[0];
                    end
                    3'd4:
                    begin
                        mul_a = DW'(full_reg[1]);
                        mul_b = n_cur[1];
                    end
                    default:
                    begin
                        mul_a = DW'(full_reg[2]);
                        mul_b = n_cur[2];
                    end
                endcase
            end
            S_CH:
            begin
                if (step_reg == 3'd0)
                begin
                    mul_a = DW'(part_reg[2]);
                    mul_b = n_cur[1];
                    mul_c = DW'(part_reg[1]);
                end
                else
                begin
                    mul_a = cnt_reg;
                    mul_b = n_cur[0];
                    mul_c = DW'(part_reg[0]) + DW'(1);
                end
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        mul_prod = mul_a * mul_b;
        mul_p    = DW'(mul_prod) + mul_c;
    end

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        num_next   = num_reg;
        step_next  = step_reg;
        face_next  = face_reg;
        id_next    = id_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        cnt_next   = cnt_reg;
        for (int d = 0; d < 3; d++)
        begin
            g_next[d]    = g_reg[d];
            full_next[d] = full_reg[d];
            part_next[d] = part_reg[d];
        end
        wid_we    = 1'b0;
        div_start = 1'b0;
        div_a     = k_val;
        div_b     = n_cur[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CNT;
                    lvl_next   = '0;
                    step_next  = '0;
                    num_next   = lvl_sat;
                    face_next  = item.face;
                    id_next    = ID_WIDTH'(item.cell_id);
                    acc_next   = '0;
                    total_next = '0;
                    for (int d = 0; d < 3; d++)
                    begin
                        g_next[d]    = '0;
                        full_next[d] = GW'(1);
                    end
                end
            end
            S_CNT:
            begin
                cnt_next = mul_p;
                if (step_reg == 3'd0)
                    step_next = 3'd1;
                else
                begin
                    step_next  = 3'd0;
                    state_next = S_FIELD;
                end
            end
            S_FIELD:
            begin
                wid_we     = 1'b1;
                total_next = total_reg + TW'(wid_new);
                id_next    = id_reg >> wid_new;
                div_start  = 1'b1;
                div_a      = k_val;
                div_b      = n_cur[0];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (step_reg == 3'd0)
                    begin
                        part_next[0] = div_rem;
                        div_start    = 1'b1;
                        div_a        = div_quot;
                        div_b        = n_cur[1];
                        step_next    = 3'd1;
                    end
                    else
                    begin
                        part_next[1] = div_rem;
                        part_next[2] = div_quot[DIM_WIDTH-1:0];
                        step_next    = 3'd0;
                        state_next   = S_FOLD;
                    end
                end
            end
            S_FOLD:
            begin
                case (step_reg)
                    3'd0:    g_next[0]    = GW'(mul_p);
                    3'd1:    g_next[1]    = GW'(mul_p);
                    3'd2:    g_next[2]    = GW'(mul_p);
                    3'd3:    full_next[0] = GW'(mul_p);
                    3'd4:    full_next[1] = GW'(mul_p);
                    default: full_next[2] = GW'(mul_p);
                endcase
                if (step_reg == 3'd5)
                begin
                    step_next = 3'd0;
                    if (lvl_reg == num_reg - LW'(1))
                        state_next = S_FACE;
                    else
                    begin
                        lvl_next   = lvl_reg + LW'(1);
                        state_next = S_CNT;
                    end
                end
                else
                    step_next = step_reg + 3'd1;
            end
            S_FACE:
            begin
                for (int d = 0; d < 3; d++)
                    g_next[d] = g_face[d];
                state_next = S_ESTART;
            end
            S_ESTART:
            begin
                div_start  = 1'b1;
                div_a      = DW'(g_reg[0]);
                div_b      = n_cur[0];
                step_next  = 3'd0;
                state_next = S_EDIV;
            end
            S_EDIV:
            begin
                if (div_done)
                begin
                    case (step_reg)
                        3'd0:
                        begin
                            part_next[0] = div_rem;
                            g_next[0]    = GW'(div_quot);
                            div_start    = 1'b1;
                            div_a        = DW'(g_reg[1]);
                            div_b        = n_cur[1];
                            step_next    = 3'd1;
                        end
                        3'd1:
                        begin
                            part_next[1] = div_rem;
                            g_next[1]    = GW'(div_quot);
                            div_start    = 1'b1;
                            div_a        = DW'(g_reg[2]);
                            div_b        = n_cur[2];
                            step_next    = 3'd2;
                        end
                        default:
                        begin
                            part_next[2] = div_rem;
                            g_next[2]    = GW'(div_quot);
                            step_next    = 3'd0;
                            state_next   = S_CH;
                        end
                    endcase
                end
            end
            S_CH:
            begin
                cnt_next = mul_p;
                if (step_reg == 3'd0)
                    step_next = 3'd1;
                else
                begin
                    step_next  = 3'd0;
                    state_next = S_PACK;
                end
            end
            S_PACK:
            begin
                acc_next = (acc_reg << wid_reg[lidx]) | ID_WIDTH'(cnt_reg);
                if (lvl_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_ESTART;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lvl_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        face_reg  <= face_next;
        id_reg    <= id_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
        cnt_reg   <= cnt_next;
        for (int d = 0; d < 3; d++)
        begin
            g_reg[d]    <= g_next[d];
            full_reg[d] <= full_next[d];
            part_reg[d] <= part_next[d];
        end
        if (wid_we)
            wid_reg[lidx] <= wid_new;
    end

    assign busy               = (state_reg != S_IDLE);
    assign done               = (state_reg == S_DONE);
    assign result.neighbor_id = NW'(acc_reg);
    assign result.too_wide    = (32'(total_reg) > ID_WIDTH);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held past one cycle");

    a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV || state_reg == S_EDIV))
        else $error("divider finished outside a wait state");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (lvl_reg < num_reg))
        else $error("level counter beyond cell level");

    a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg == S_CNT && lvl_reg == '0))
        else $error("accepted word did not start at the coarsest level");

endmodule

/* rtl/periodic_cell_neighbor_id_core.sv */
// top level: level count registers and neighbor id sequencer
`timescale 1ns / 1ps

// usage
// - input word on item, accepted at a clock edge with start high and busy low
// - result word on result, marked by done for exactly one cycle; no back-pressure
// - configuration: cfg_we, cfg_index, cfg_data; register i holds the packed
//   nx, ny, nz of level i; writes to unused indexes are dropped; write only
//   while busy is low
// - per level: two divisions on decode, three on re-encode, through one
//   restoring divider at one quotient bit per cycle; that divider sets the rate
// - one word at a time: busy stays high from accept until the done cycle
// - reset: all count registers return to nx = ny = nz = 1, sequencer idle
// - the receiver cannot stall; done is a one-cycle strobe
module periodic_cell_neighbor_id_core #(
    parameter int MAX_LEVELS = pcni_pkg::MAX_LEVELS_DEF,
    parameter int ID_WIDTH   = pcni_pkg::ID_WIDTH_DEF,
    parameter int DIM_WIDTH  = pcni_pkg::DIM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  pcni_pkg::in_t                   item,
    output logic                            busy,
    output logic                            done,
    output pcni_pkg::out_t                  result,
    input  logic                            cfg_we,
    input  logic [pcni_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcni_pkg::REG_W-1:0]      cfg_data
);

    localparam int RW = pcni_pkg::REG_W;
    localparam logic [RW-1:0] DIMS_RESET = RW'(1) | (RW'(1) << DIM_WIDTH)
                                         | (RW'(1) << (2 * DIM_WIDTH));

    logic [MAX_LEVELS-1:0][RW-1:0] dims_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
                dims_reg[l] <= DIMS_RESET;
        end
        else if (cfg_we)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                if (l < pcni_pkg::NUM_REGS && 32'(cfg_index) == l)
                    dims_reg[l] <= cfg_data;
            end
        end
    end

    pcni_seq #(
        .MAX_LEVELS (MAX_LEVELS),
        .ID_WIDTH   (ID_WIDTH),
        .DIM_WIDTH  (DIM_WIDTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .dims   (dims_reg),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

endmodule
